>>> hw/rtl/ldtw_pkg.sv
package ldtw_pkg;

    localparam int OPCODE_W     = 2;
    localparam int GRID_ADDR_W  = 4;
    localparam int PAYLOAD_W    = 8;
    localparam int BYTE_W       = 8;
    localparam int IN_TDATA_W   = 16;
    localparam int OUT_TDATA_W  = 8;
    localparam int BIT_IDX_W    = 3;

    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [OPCODE_W-1:0] OP_RAW_CMD  = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_DIGIT    = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_LED_BYTE = 2'd2;
    localparam logic [OPCODE_W-1:0] OP_UNUSED   = 2'd3;

    localparam logic [BYTE_W-1:0] GRID_CMD_BASE = 8'hc0;
    localparam logic [BYTE_W-1:0] LED_CMD_RESET = 8'd200;
    localparam logic [BIT_IDX_W-1:0] LAST_BIT   = 3'd7;

    // one frame as the sequencer sees it
    typedef struct packed {
        logic [BYTE_W-1:0] first_byte;
        logic [BYTE_W-1:0] second_byte;
        logic              two_bytes;
    } t_frame;

    // seven-segment pattern, codes 10..19 add the dot, 20 and above blank
    function automatic logic [BYTE_W-1:0] seg_lookup(input logic [PAYLOAD_W-1:0] code);
        logic [BYTE_W-1:0] seg;
        unique case (code)
            8'd0:    seg = 8'h3f;
            8'd1:    seg = 8'h06;
            8'd2:    seg = 8'h5b;
            8'd3:    seg = 8'h4f;
            8'd4:    seg = 8'h66;
            8'd5:    seg = 8'h6d;
            8'd6:    seg = 8'h7d;
            8'd7:    seg = 8'h07;
            8'd8:    seg = 8'h7f;
            8'd9:    seg = 8'h6f;
            8'd10:   seg = 8'hbf;
            8'd11:   seg = 8'h86;
            8'd12:   seg = 8'hdb;
            8'd13:   seg = 8'hcf;
            8'd14:   seg = 8'he6;
            8'd15:   seg = 8'hed;
            8'd16:   seg = 8'hfd;
            8'd17:   seg = 8'h87;
            8'd18:   seg = 8'hff;
            8'd19:   seg = 8'hef;
            default: seg = 8'h00;
        endcase
        return seg;
    endfunction

endpackage

>>> hw/rtl/ldtw_front.sv
module ldtw_front
    import ldtw_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [BYTE_W-1:0]     i_cfg_wdata,
    input  logic                  i_tvalid,
    output logic                  o_tready,
    input  logic [OPCODE_W-1:0]   i_opcode,
    input  logic [GRID_ADDR_W-1:0] i_grid_address,
    input  logic [PAYLOAD_W-1:0]  i_payload,
    input  logic                  i_q_full,
    output logic                  o_push,
    output t_frame                o_frame
);

    logic [BYTE_W-1:0] r_led_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_led_cmd <= LED_CMD_RESET;
        end else if (i_cfg_we) begin
            r_led_cmd <= i_cfg_wdata;
        end
    end

    assign o_tready = !i_q_full;

    // unused opcode is taken and dropped
    assign o_push = i_tvalid && !i_q_full && (i_opcode != OP_UNUSED);

    always_comb begin
        o_frame.first_byte  = i_payload;
        o_frame.second_byte = '0;
        o_frame.two_bytes   = 1'b0;
        unique case (i_opcode)
            OP_RAW_CMD: begin
                o_frame.first_byte = i_payload;
            end
            OP_DIGIT: begin
                o_frame.first_byte  = GRID_CMD_BASE + {{(BYTE_W-GRID_ADDR_W){1'b0}}, i_grid_address};
                o_frame.second_byte = seg_lookup(i_payload);
                o_frame.two_bytes   = 1'b1;
            end
            OP_LED_BYTE: begin
                o_frame.first_byte  = r_led_cmd;
                o_frame.second_byte = i_payload;
                o_frame.two_bytes   = 1'b1;
            end
            default: begin
                o_frame.two_bytes = 1'b0;
            end
        endcase
    end

endmodule

>>> hw/rtl/ldtw_queue.sv
module ldtw_queue
    import ldtw_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_frame i_frame,
    output logic   o_full,
    input  logic   i_pop,
    output logic   o_head_valid,
    output t_frame o_head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_frame             r_entry [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic [PTR_W-1:0]   n_wr_ptr;
    logic [PTR_W-1:0]   n_rd_ptr;

    assign o_full       = (r_count == CNT_W'(DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_entry[r_rd_ptr];

    assign n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
    assign n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_frame;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop))
        else $error("frame queue overflow");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("frame queue count out of range");

endmodule

>>> hw/rtl/ldtw_back.sv
module ldtw_back
    import ldtw_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_head_valid,
    input  t_frame i_head,
    output logic   o_pop,
    output logic   o_tvalid,
    input  logic   i_tready,
    output logic   o_clock_level,
    output logic   o_data_level,
    output logic   o_frame_end
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_START = 2'd1;
    localparam logic [1:0] ST_BITS  = 2'd2;
    localparam logic [1:0] ST_STOP  = 2'd3;

    logic [1:0]           r_state, n_state;
    logic [1:0]           r_phase, n_phase;
    logic [BIT_IDX_W-1:0] r_bit, n_bit;
    logic                 r_sel, n_sel;
    logic                 r_two, n_two;
    logic                 r_prev, n_prev;
    logic [BYTE_W-1:0]    r_byte, n_byte;
    logic [BYTE_W-1:0]    r_second, n_second;

    logic r_out_valid;
    logic r_out_clk;
    logic r_out_dat;
    logic r_out_end;

    logic w_adv;
    logic w_slot_clk;
    logic w_slot_dat;
    logic w_slot_end;

    assign w_adv = (r_state != ST_IDLE) && (!r_out_valid || i_tready);

    always_comb begin
        n_state    = r_state;
        n_phase    = r_phase;
        n_bit      = r_bit;
        n_sel      = r_sel;
        n_two      = r_two;
        n_prev     = r_prev;
        n_byte     = r_byte;
        n_second   = r_second;
        o_pop      = 1'b0;
        w_slot_clk = 1'b0;
        w_slot_dat = 1'b0;
        w_slot_end = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_head_valid) begin
                    o_pop    = 1'b1;
                    n_byte   = i_head.first_byte;
                    n_second = i_head.second_byte;
                    n_two    = i_head.two_bytes;
                    n_state  = ST_START;
                    n_phase  = 2'd0;
                end
            end
            ST_START: begin
                w_slot_clk = (r_phase != 2'd2);
                w_slot_dat = (r_phase == 2'd0);
                if (w_adv) begin
                    if (r_phase == 2'd2) begin
                        n_state = ST_BITS;
                        n_phase = 2'd0;
                        n_bit   = '0;
                        n_sel   = 1'b0;
                        n_prev  = 1'b0;
                    end else begin
                        n_phase = r_phase + 2'd1;
                    end
                end
            end
            ST_BITS: begin
                w_slot_clk = (r_phase == 2'd2);
                w_slot_dat = (r_phase == 2'd0) ? r_prev : r_byte[0];
                if (w_adv) begin
                    if (r_phase == 2'd2) begin
                        n_phase = 2'd0;
                        n_prev  = r_byte[0];
                        n_byte  = {1'b0, r_byte[BYTE_W-1:1]};
                        n_bit   = r_bit + 1'b1;
                        if (r_bit == LAST_BIT) begin
                            if (!r_sel && r_two) begin
                                n_byte = r_second;
                                n_sel  = 1'b1;
                                n_prev = 1'b0;
                                n_bit  = '0;
                            end else begin
                                n_state = ST_STOP;
                            end
                        end
                    end else begin
                        n_phase = r_phase + 2'd1;
                    end
                end
            end
            ST_STOP: begin
                w_slot_clk = 1'b1;
                w_slot_dat = (r_phase == 2'd1);
                w_slot_end = (r_phase == 2'd1);
                if (w_adv) begin
                    if (r_phase == 2'd1) begin
                        n_phase = 2'd0;
                        if (i_head_valid) begin
                            o_pop    = 1'b1;
                            n_byte   = i_head.first_byte;
                            n_second = i_head.second_byte;
                            n_two    = i_head.two_bytes;
                            n_state  = ST_START;
                        end else begin
                            n_state = ST_IDLE;
                        end
                    end else begin
                        n_phase = r_phase + 2'd1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_phase     <= '0;
            r_bit       <= '0;
            r_sel       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_bit   <= n_bit;
            r_sel   <= n_sel;
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_two    <= n_two;
        r_prev   <= n_prev;
        r_byte   <= n_byte;
        r_second <= n_second;
        if (w_adv) begin
            r_out_clk <= w_slot_clk;
            r_out_dat <= w_slot_dat;
            r_out_end <= w_slot_end;
        end
    end

    assign o_tvalid      = r_out_valid;
    assign o_clock_level = r_out_clk;
    assign o_data_level  = r_out_dat;
    assign o_frame_end   = r_out_end;

    a_pop_needs_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> i_head_valid)
        else $error("pop from empty frame queue");

    a_stop_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_STOP) |-> (r_phase <= 2'd1))
        else $error("stop phase out of range");

    a_idle_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_state == ST_STOP && r_phase == 2'd1 && !i_head_valid)
        |=> (r_state == ST_IDLE))
        else $error("sequencer did not go idle after frame end");

endmodule

>>> hw/rtl/led_digit_two_wire_writer_unit.sv
// two-wire led driver frame writer: each request word on the slave stream becomes one
// frame of pin slots on the master stream, one output word per slot (clock level, data
// level, tlast on the final stop slot). opcode 0 sends the payload as one raw command byte,
// opcode 1 sends 0xc0 plus the grid address and then the seven-segment byte for digit code
// payload (0..9 digits, 10..19 digits with dot, 20 and above blank), opcode 2 sends the
// led command register and then the payload; opcode 3 is accepted and dropped. a frame is
// a start (3 slots), 3 slots per bit lsb first, and a stop (2 slots): 29 output words for
// one byte, 53 for two. the slot sequencer issues one output word per cycle while the
// master side keeps tready high; an idle sequencer takes the next frame from its idle
// state. a small frame queue sits between the request decoder and the sequencer, so
// requests are taken while a frame is going out. the user must write the command register
// through i_cfg_we / i_cfg_wdata only while the block is idle, which it does not enforce.
module led_digit_two_wire_writer_unit
    import ldtw_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,

    // led command register write
    input  logic                   i_cfg_we,
    input  logic [BYTE_W-1:0]      i_cfg_wdata,

    // request words
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,   // grid_address [3:0], payload [11:4], zero
    input  logic [OPCODE_W-1:0]    i_s_axis_tuser,   // opcode [1:0]

    // pin slot words
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,   // clock_level [0], data_level [1], zero
    output logic                   o_m_axis_tlast    // frame_end
);

    // decoded frame handed to the queue
    t_frame w_push_frame;
    logic   w_push;
    logic   w_q_full;

    // queue head towards the sequencer
    t_frame w_head;
    logic   w_head_valid;
    logic   w_pop;

    logic   w_clock_level;
    logic   w_data_level;

    // request decoder and command register
    ldtw_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_tvalid       (i_s_axis_tvalid),
        .o_tready       (o_s_axis_tready),
        .i_opcode       (i_s_axis_tuser),
        .i_grid_address (i_s_axis_tdata[GRID_ADDR_W-1:0]),
        .i_payload      (i_s_axis_tdata[GRID_ADDR_W+PAYLOAD_W-1:GRID_ADDR_W]),
        .i_q_full       (w_q_full),
        .o_push         (w_push),
        .o_frame        (w_push_frame)
    );

    // frame queue, decouples decoding from slot output
    ldtw_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .i_frame      (w_push_frame),
        .o_full       (w_q_full),
        .i_pop        (w_pop),
        .o_head_valid (w_head_valid),
        .o_head       (w_head)
    );

    // slot sequencer with registered output word
    ldtw_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head_valid  (w_head_valid),
        .i_head        (w_head),
        .o_pop         (w_pop),
        .o_tvalid      (o_m_axis_tvalid),
        .i_tready      (i_m_axis_tready),
        .o_clock_level (w_clock_level),
        .o_data_level  (w_data_level),
        .o_frame_end   (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {{(OUT_TDATA_W-2){1'b0}}, w_data_level, w_clock_level};

endmodule

>>> bench/ldtw_slot_checker.sv
`timescale 1ns / 1ps

module ldtw_slot_checker
    import ldtw_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,

    input  logic                   i_cfg_we,
    input  logic [BYTE_W-1:0]      i_cfg_wdata,

    input  logic                   i_s_tvalid,
    input  logic                   i_s_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,   // grid_address [3:0], payload [11:4], zero
    input  logic [OPCODE_W-1:0]    i_s_tuser,   // opcode [1:0]

    input  logic                   i_m_tvalid,
    input  logic                   i_m_tready,
    input  logic [OUT_TDATA_W-1:0] i_m_tdata,   // clock_level [0], data_level [1], zero
    input  logic                   i_m_tlast,   // frame_end

    output int                     o_fail_count,
    output int                     o_pending
);

    typedef struct packed {
        logic clock_level;
        logic data_level;
        logic frame_end;
    } t_pin_slot;

    t_pin_slot         slot_q[$];
    logic [BYTE_W-1:0] grid_cmd = LED_CMD_RESET;
    int                fails = 0;

    assign o_fail_count = fails;

    // digits 10..19 are the plain digit with the dot segment lit
    function automatic logic [BYTE_W-1:0] digit_segments(input logic [PAYLOAD_W-1:0] code);
        logic [BYTE_W-1:0] seg;
        logic [3:0]        digit;
        digit = (code >= 8'd10) ? 4'(code - 8'd10) : code[3:0];
        case (digit)
            4'd0:    seg = 8'h3f;
            4'd1:    seg = 8'h06;
            4'd2:    seg = 8'h5b;
            4'd3:    seg = 8'h4f;
            4'd4:    seg = 8'h66;
            4'd5:    seg = 8'h6d;
            4'd6:    seg = 8'h7d;
            4'd7:    seg = 8'h07;
            4'd8:    seg = 8'h7f;
            default: seg = 8'h6f;
        endcase
        if (code > 8'd20) begin
            seg = 8'h00;
        end else if (code == 8'd20) begin
            seg = 8'h00;
        end else if (code >= 8'd10) begin
            seg = seg | 8'h80;
        end
        return seg;
    endfunction

    function automatic void push_slot(input logic clk_lvl, input logic dat_lvl,
                                      input logic last_lvl);
        t_pin_slot s;
        s.clock_level = clk_lvl;
        s.data_level  = dat_lvl;
        s.frame_end   = last_lvl;
        slot_q.push_back(s);
    endfunction

    // lsb first, the data pin starts each byte low
    function automatic void push_byte(input logic [BYTE_W-1:0] value);
        logic prev;
        prev = 1'b0;
        for (int k = 0; k < BYTE_W; k++) begin
            push_slot(1'b0, prev, 1'b0);
            push_slot(1'b0, value[k], 1'b0);
            push_slot(1'b1, value[k], 1'b0);
            prev = value[k];
        end
    endfunction

    function automatic void predict_frame(input logic [OPCODE_W-1:0] op,
                                          input logic [GRID_ADDR_W-1:0] addr,
                                          input logic [PAYLOAD_W-1:0] payload);
        if (op == OP_UNUSED) return;
        push_slot(1'b1, 1'b1, 1'b0);
        push_slot(1'b1, 1'b0, 1'b0);
        push_slot(1'b0, 1'b0, 1'b0);
        case (op)
            OP_RAW_CMD: begin
                push_byte(payload);
            end
            OP_DIGIT: begin
                push_byte(GRID_CMD_BASE + BYTE_W'(addr));
                push_byte(digit_segments(payload));
            end
            default: begin
                push_byte(grid_cmd);
                push_byte(payload);
            end
        endcase
        push_slot(1'b1, 1'b0, 1'b0);
        push_slot(1'b1, 1'b1, 1'b1);
    endfunction

    always @(posedge i_clk) begin
        t_pin_slot want;
        if (!i_rst_n) begin
            slot_q.delete();
            grid_cmd = LED_CMD_RESET;
        end else begin
            if (i_cfg_we) begin
                grid_cmd = i_cfg_wdata;
            end
            if (i_m_tvalid && i_m_tready) begin
                if (slot_q.size() == 0) begin
                    $error("unexpected slot word tdata=%0h tlast=%0b", i_m_tdata, i_m_tlast);
                    fails++;
                end else begin
                    want = slot_q.pop_front();
                    if (i_m_tdata[0] !== want.clock_level) begin
                        $error("clock_level expected %0b actual %0b",
                               want.clock_level, i_m_tdata[0]);
                        fails++;
                    end
                    if (i_m_tdata[1] !== want.data_level) begin
                        $error("data_level expected %0b actual %0b",
                               want.data_level, i_m_tdata[1]);
                        fails++;
                    end
                    if (i_m_tlast !== want.frame_end) begin
                        $error("frame_end expected %0b actual %0b",
                               want.frame_end, i_m_tlast);
                        fails++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                predict_frame(i_s_tuser, i_s_tdata[3:0], i_s_tdata[11:4]);
            end
        end
        o_pending <= slot_q.size();
    end

endmodule

>>> bench/led_digit_two_wire_writer_unit_tb.sv
`timescale 1ns / 1ps

module led_digit_two_wire_writer_unit_tb;
    import ldtw_pkg::*;

    // cycles with no word moving on either side before the run is given up
    localparam int STALL_LIMIT  = 3000;
    // receiver hold-off long enough to fill the frame queue
    localparam int HOLD_CYCLES  = 400;
    // settle time after the last slot, covers dropped requests still in flight
    localparam int SETTLE       = 16;
    localparam int RANDOM_PHASE = 42;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [BYTE_W-1:0]      i_cfg_wdata;
    logic                   i_s_axis_tvalid;
    logic                   o_s_axis_tready;
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata;   // grid_address [3:0], payload [11:4], zero
    logic [OPCODE_W-1:0]    i_s_axis_tuser;   // opcode [1:0]
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;   // clock_level [0], data_level [1], zero
    logic                   o_m_axis_tlast;   // frame_end

    int fail_count;
    int slots_pending;
    int stall_cycles;
    int burst_left;

    led_digit_two_wire_writer_unit uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    ldtw_slot_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_s_tvalid   (i_s_axis_tvalid),
        .i_s_tready   (o_s_axis_tready),
        .i_s_tdata    (i_s_axis_tdata),
        .i_s_tuser    (i_s_axis_tuser),
        .i_m_tvalid   (o_m_axis_tvalid),
        .i_m_tready   (i_m_axis_tready),
        .i_m_tdata    (o_m_axis_tdata),
        .i_m_tlast    (o_m_axis_tlast),
        .o_fail_count (fail_count),
        .o_pending    (slots_pending)
    );

    // 2 ns clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // watchdog: restarts whenever a word moves on either side
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stall_cycles <= 0;
        end else if ((i_s_axis_tvalid && o_s_axis_tready) ||
                     (o_m_axis_tvalid && i_m_axis_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("led_digit_two_wire_writer_unit test failed");
                $finish;
            end
        end
    end

    // receiver: segments of different ready patterns, one long hold-off early on
    initial begin
        int pattern;
        int seg_len;
        int seg_count;
        i_m_axis_tready <= 1'b0;
        seg_count = 0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (seg_count == 3) begin
                // sender keeps offering, so the frame queue fills and input stalls
                repeat (HOLD_CYCLES) begin
                    i_m_axis_tready <= 1'b0;
                    @(posedge i_clk);
                end
            end else begin
                pattern = $urandom_range(0, 3);
                seg_len = $urandom_range(10, 150);
                repeat (seg_len) begin
                    case (pattern)
                        0:       i_m_axis_tready <= 1'b1;
                        1:       i_m_axis_tready <= 1'($urandom_range(0, 1));
                        2:       i_m_axis_tready <= ($urandom_range(0, 7) != 0);
                        default: i_m_axis_tready <= ($urandom_range(0, 3) == 0);
                    endcase
                    @(posedge i_clk);
                end
            end
            seg_count++;
        end
    end

    // offer one request word; bursts of back-to-back words with random gaps between
    task automatic offer_request(input logic [OPCODE_W-1:0] op,
                                 input logic [GRID_ADDR_W-1:0] addr,
                                 input logic [PAYLOAD_W-1:0] payload);
        int gap;
        if (burst_left == 0) begin
            gap        = $urandom_range(0, 12);
            burst_left = $urandom_range(1, 8);
            if (gap > 0) begin
                i_s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {4'b0000, payload, addr};
        i_s_axis_tuser  <= op;
        do @(posedge i_clk); while (!o_s_axis_tready);
    endtask

    // stop offering and wait until every predicted slot word has come out
    task automatic wait_idle();
        i_s_axis_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (slots_pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_grid_cmd(input logic [BYTE_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // random requests, mostly digit and led byte frames, a few dropped opcodes
    task automatic random_requests(input int count);
        int                   sent;
        int                   pick;
        logic [OPCODE_W-1:0]  op;
        logic [PAYLOAD_W-1:0] payload;
        sent = 0;
        while (sent < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 8)       op = OP_UNUSED;
            else if (pick < 45) op = OP_DIGIT;
            else if (pick < 70) op = OP_RAW_CMD;
            else                op = OP_LED_BYTE;
            if (op == OP_DIGIT && $urandom_range(0, 9) != 0) begin
                payload = PAYLOAD_W'($urandom_range(0, 20));
            end else begin
                payload = PAYLOAD_W'($urandom_range(0, 255));
            end
            offer_request(op, GRID_ADDR_W'($urandom_range(0, 15)), payload);
            if (op != OP_UNUSED) sent++;
        end
    endtask

    initial begin
        burst_left = 0;
        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_wdata     <= '0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        i_s_axis_tuser  <= OP_RAW_CMD;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed, register at its reset value
        offer_request(OP_RAW_CMD,  4'd0,  8'h00);
        offer_request(OP_RAW_CMD,  4'd15, 8'hff);
        offer_request(OP_RAW_CMD,  4'd5,  8'h01);
        offer_request(OP_RAW_CMD,  4'd10, 8'h80);
        offer_request(OP_RAW_CMD,  4'd3,  8'ha5);
        offer_request(OP_DIGIT,    4'd0,  8'd0);
        offer_request(OP_DIGIT,    4'd15, 8'd9);
        offer_request(OP_DIGIT,    4'd7,  8'd10);
        offer_request(OP_DIGIT,    4'd8,  8'd19);
        // blank code and codes past the table
        offer_request(OP_DIGIT,    4'd1,  8'd20);
        offer_request(OP_DIGIT,    4'd2,  8'd21);
        offer_request(OP_DIGIT,    4'd14, 8'hff);
        offer_request(OP_LED_BYTE, 4'd0,  8'h00);
        offer_request(OP_LED_BYTE, 4'd15, 8'hff);
        // dropped opcode between real frames
        offer_request(OP_UNUSED,   4'd15, 8'hff);
        offer_request(OP_LED_BYTE, 4'd9,  8'h5a);
        offer_request(OP_UNUSED,   4'd0,  8'h00);
        wait_idle();

        // register extremes
        write_grid_cmd(8'h00);
        offer_request(OP_LED_BYTE, 4'd0,  8'hff);
        offer_request(OP_LED_BYTE, 4'd6,  8'h3c);
        wait_idle();
        write_grid_cmd(8'hff);
        offer_request(OP_LED_BYTE, 4'd15, 8'h00);
        offer_request(OP_LED_BYTE, 4'd4,  8'hc3);
        wait_idle();

        // random phases, register changed between them
        random_requests(RANDOM_PHASE);
        wait_idle();
        write_grid_cmd(8'h00);
        random_requests(RANDOM_PHASE);
        wait_idle();
        write_grid_cmd(BYTE_W'($urandom_range(0, 255)));
        random_requests(RANDOM_PHASE);
        wait_idle();
        write_grid_cmd(8'hff);
        random_requests(RANDOM_PHASE);
        wait_idle();
        write_grid_cmd(BYTE_W'($urandom_range(0, 255)));
        random_requests(RANDOM_PHASE);
        wait_idle();

        if (fail_count == 0) begin
            $display("led_digit_two_wire_writer_unit test passed");
        end else begin
            $display("led_digit_two_wire_writer_unit test failed");
        end
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/ldtw_pkg.sv
hw/rtl/ldtw_front.sv
hw/rtl/ldtw_queue.sv
hw/rtl/ldtw_back.sv
hw/rtl/led_digit_two_wire_writer_unit.sv
bench/ldtw_slot_checker.sv
bench/led_digit_two_wire_writer_unit_tb.sv
